// ===== hw/rtl/integer_to_decimal_ascii_defines.svh =====
// assertion macros used by the decimal ascii converter top level
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// condition now implies consequence in the same cycle
`define ITDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition now implies consequence in the next cycle
`define ITDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/itda_pkg.sv =====
// package with widths, constants and types for the decimal ascii converter
`timescale 1ns / 1ps

package itda_pkg;

  localparam int VALUE_W    = 64;
  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(MAX_DIGITS + 1);
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;

  typedef struct packed {
    logic done;
    logic ovf;
  } conv_status_t;

  // double dabble correction of one bcd digit
  function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    return r;
  endfunction

endpackage

// ===== hw/rtl/itda_bin2bcd.sv =====
// bit-serial binary to bcd converter, one input bit per cycle
`timescale 1ns / 1ps

module itda_bin2bcd import itda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic [BCD_W-1:0]   bcd,
  output conv_status_t       status
);

  logic [VALUE_W-1:0] shreg;
  logic [CNT_W-1:0]   bit_cnt;
  logic               busy;
  logic               done;
  logic               ovf;
  logic [BCD_W-1:0]   adj;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = add3(bcd[i*DIGIT_W +: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + CNT_W'(1);
        if (bit_cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      bcd   <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_W-1]};
      // a bit pushed out of the top digit means the value exceeds the digit limit
      ovf   <= ovf | adj[BCD_W-1];
    end
  end

  assign status.done = done;
  assign status.ovf  = ovf;

endmodule

// ===== hw/rtl/integer_to_decimal_ascii.sv =====
// Unsigned 64-bit integer to decimal ASCII text. Each accepted item is
// converted by a bit-serial double dabble unit, one input bit per cycle,
// after the accept cycle. The digits then leave most significant first,
// one character per cycle while out_ready is high; leading zeros are dropped
// at one per cycle without output. The digits are followed by the terminator
// character, which carries is_last and total_length (digits plus one).
// in_ready is high only between items; the terminator may still wait in the
// output register while the next item is taken. terminator_char is written
// through terminator_char_we.
`timescale 1ns / 1ps
`include "integer_to_decimal_ascii_defines.svh"

module integer_to_decimal_ascii import itda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               terminator_char_we,
  input  logic [CHAR_W-1:0]  terminator_char,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char,
  output logic               is_last,
  output logic [LEN_W-1:0]   total_length
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_TERM = 2'd3;

  logic [1:0]         state;
  logic [CHAR_W-1:0]  term;
  logic [BCD_W-1:0]   digits;
  logic [REM_W-1:0]   rem;
  logic               started;
  logic [LEN_W-1:0]   len;
  logic [BCD_W-1:0]   conv_bcd;
  conv_status_t       conv_st;
  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic [DIGIT_W-1:0] top;
  logic               skip;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign top      = digits[BCD_W-1 -: DIGIT_W];
  assign skip     = !started && (top == '0) && (rem > REM_W'(1));
  assign out_load = out_free && ((state == S_EMIT && !skip) || state == S_TERM);

  itda_bin2bcd u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .value  (value),
    .bcd    (conv_bcd),
    .status (conv_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      term <= '0;
    end else if (terminator_char_we) begin
      term <= terminator_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      rem       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_st.done) begin
            state   <= S_EMIT;
            rem     <= REM_W'(MAX_DIGITS);
            // past the digit limit every remaining digit is kept
            started <= conv_st.ovf;
          end
        end
        S_EMIT: begin
          if (skip) begin
            rem <= rem - REM_W'(1);
          end else if (out_free) begin
            started   <= 1'b1;
            rem       <= rem - REM_W'(1);
            if (rem == REM_W'(1)) begin
              state <= S_TERM;
            end
          end
        end
        S_TERM: begin
          if (out_free) begin
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CONV && conv_st.done) begin
      digits <= conv_bcd;
      len    <= LEN_W'(MAX_DIGITS + 1);
    end else if (state == S_EMIT) begin
      if (skip) begin
        digits <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end else if (out_free) begin
        digits       <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        out_char     <= ASCII_ZERO + CHAR_W'(top);
        is_last      <= 1'b0;
        total_length <= '0;
        if (!started) begin
          len <= LEN_W'(rem) + LEN_W'(1);
        end
      end
    end else if (state == S_TERM && out_free) begin
      out_char     <= term;
      is_last      <= 1'b1;
      total_length <= len;
    end
  end

  `ITDA_ASSERT_NEXT(a_accept_starts_conv, in_acc, state == S_CONV, "accept did not start conversion")
  `ITDA_ASSERT_NOW(a_done_in_conv, conv_st.done, state == S_CONV, "conversion done outside conversion phase")
  `ITDA_ASSERT_NOW(a_emit_rem_nonzero, state == S_EMIT, rem != '0, "digit count ran out during emit")
  `ITDA_ASSERT_NOW(a_last_len_range, out_valid && is_last, total_length >= LEN_W'(2) && total_length <= LEN_W'(MAX_DIGITS + 1), "terminator length out of range")

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the 64-bit integer to decimal ascii converter
`timescale 1ns / 1ps

module tb_top import itda_pkg::*;;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          SETTLE_CYCLES = 100;

  // receiver stall patterns
  localparam int RX_FREE     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [LEN_W-1:0]  len;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               terminator_char_we = 1'b0;
  logic [CHAR_W-1:0]  terminator_char = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_char;
  logic               is_last;
  logic [LEN_W-1:0]   total_length;

  text_char_t         expected_chars[$];
  logic [CHAR_W-1:0]  term_shadow = '0;
  int unsigned        err_count = 0;
  int unsigned        items_sent = 0;
  int unsigned        chars_checked = 0;
  int unsigned        term_writes = 0;
  int unsigned        cycle_count = 0;

  // sender burst control
  bit                 bursty = 1'b1;
  int                 burst_left = 0;

  // receiver control: hold-off requested by bumping hold_tag
  bit                 rx_force_free = 1'b0;
  int                 hold_len = 0;
  int                 hold_tag = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 rx_mode = RX_FREE;
  int                 rx_span = 0;
  int                 rx_phase = 0;

  integer_to_decimal_ascii u_dut (
    .clk                (clk),
    .rst                (rst),
    .terminator_char_we (terminator_char_we),
    .terminator_char    (terminator_char),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .value              (value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .is_last            (is_last),
    .total_length       (total_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still expected",
               cycle_count, expected_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // expected text of one value: digits msd first, then the terminator item
  function automatic void predict_decimal_text(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] digs[MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    text_char_t         c;
    rest = v;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(rest % 64'd10);
      rest = rest / 64'd10;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = ASCII_ZERO + CHAR_W'(digs[k]);
      c.last = 1'b0;
      c.len  = '0;
      expected_chars.insert(expected_chars.size(), c);
    end
    c.ch   = term_shadow;
    c.last = 1'b1;
    c.len  = LEN_W'(n + 1);
    expected_chars.insert(expected_chars.size(), c);
  endfunction

  function automatic logic [VALUE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VALUE_W-1:0] pow10(input int n);
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // random value with exactly n decimal digits
  function automatic logic [VALUE_W-1:0] value_of_digits(input int n);
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    if (n <= 1) return VALUE_W'($urandom_range(0, 9));
    lo = pow10(n - 1);
    hi = (n >= MAX_DIGITS) ? '1 : pow10(n) - 64'd1;
    return lo + rand64() % (hi - lo + 64'd1);
  endfunction

  // result checker
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected char %0d (is_last %0d, total_length %0d)",
               out_char, is_last, total_length);
        err_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_char !== want.ch) begin
          $error("out_char mismatch: expected %0d, got %0d", want.ch, out_char);
          err_count++;
        end
        if (is_last !== want.last) begin
          $error("is_last mismatch: expected %0d, got %0d", want.last, is_last);
          err_count++;
        end
        if (total_length !== want.len) begin
          $error("total_length mismatch: expected %0d, got %0d",
                 want.len, total_length);
          err_count++;
        end
      end
    end
  end

  // receiver: own stall pattern, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_len;
    end
    if (rx_span == 0) begin
      rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
      rx_span = $urandom_range(20, 300);
    end else begin
      rx_span--;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_force_free || rx_mode == RX_FREE) begin
      out_ready <= 1'b1;
    end else if (rx_mode == RX_RANDOM) begin
      out_ready <= ($urandom_range(0, 99) >= 40);
    end else begin
      out_ready <= ((rx_phase % 5) < 3);
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(1, 15);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk); while (!in_ready);
    predict_decimal_text(v);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic set_terminator(input logic [CHAR_W-1:0] t);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    terminator_char_we = 1'b1;
    terminator_char    = t;
    @(negedge clk);
    terminator_char_we = 1'b0;
    term_shadow = t;
    term_writes++;
  endtask

  task automatic send_mixed_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5)
      send_value(value_of_digits($urandom_range(1, MAX_DIGITS)));
    else if (kind <= 7)
      send_value(rand64());
    else if (kind == 8)
      send_value(pow10($urandom_range(0, 19)) - VALUE_W'($urandom_range(0, 1)));
    else
      send_value(VALUE_W'($urandom_range(0, 20)));
  endtask

  // edge values, first with the reset terminator
  task automatic test_directed_values();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd1000000007);
    send_value(pow10(18));
    send_value(pow10(19) - 64'd1);
    send_value(pow10(19));
    send_value(64'h8000_0000_0000_0000);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'd12345678901234567890);
    send_value('1);
    set_terminator(8'hFF);
    send_value(64'd0);
    send_value('1);
    send_value(64'd7);
  endtask

  // several terminator settings, extremes included
  task automatic test_terminator_sweep();
    logic [CHAR_W-1:0] terms[6];
    terms = '{8'h00, 8'h0A, 8'h80, 8'h7F, 8'h55, 8'hFF};
    foreach (terms[i]) begin
      set_terminator(terms[i]);
      repeat (12) send_mixed_value();
    end
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_output_backpressure();
    wait_drain();
    @(posedge clk);
    hold_len = 600;
    hold_tag++;
    bursty = 1'b0;
    repeat (6) send_mixed_value();
    bursty = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_values(input int n, input bit no_idle);
    bursty        = !no_idle;
    rx_force_free = no_idle;
    repeat (n) send_mixed_value();
    bursty        = 1'b1;
    rx_force_free = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_values();
    test_terminator_sweep();
    test_output_backpressure();
    set_terminator(8'($urandom_range(0, 255)));
    test_random_values(150, 1'b0);
    test_random_values(60, 1'b1);
    set_terminator(8'($urandom_range(0, 255)));
    test_random_values(160, 1'b0);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("converted %0d values into %0d checked chars", items_sent, chars_checked);
    $display("terminator written %0d times, incl. 0x00 and 0xff; %0d cycles",
             term_writes, cycle_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/itda_pkg.sv
hw/rtl/itda_bin2bcd.sv
hw/rtl/integer_to_decimal_ascii.sv
tb/tb_top.sv
